@@ rtl/spfd_pkg.sv @@
// Package for the S.BUS pulse frame decoder: sizes, constants, state codes
// and the pulse width to bit count conversion. No dependencies.
`default_nettype none

package spfd_pkg;

  localparam int US_PER_BIT   = 10;
  localparam int FRAME_BYTES  = 25;
  localparam int SLOT_BITS    = 12;
  localparam int NUM_CHANNELS = 16;
  localparam int CH_BITS      = 11;
  localparam int FLAGS_SLOT   = 23;
  localparam int MAX_HIGH_END = 10;
  localparam int BIT_SAT      = 25;
  localparam int CH_OFFSET    = 874;

  localparam int WIDTH_W = 16;
  localparam int SLOT_AW = $clog2(FRAME_BYTES + 1);
  localparam int OFS_W   = $clog2(SLOT_BITS + 1);
  localparam int CNT_W   = $clog2(BIT_SAT + 1);
  localparam int CH_AW   = $clog2(NUM_CHANNELS);
  localparam int VAL_W   = 12;
  localparam int FRM_W   = 32;
  localparam int ACC_W   = CH_BITS + 7;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WR    = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_EM_RD = 5'b01000,
    ST_EM_LD = 5'b10000
  } state_t;

  // Bit count of a duration, (x)/US_PER_BIT with x = width + 1, saturated.
  function automatic logic [CNT_W-1:0] bit_count(input logic [WIDTH_W:0] x);
    logic [CNT_W-1:0] q;
    q = '0;
    for (int i = 1; i <= BIT_SAT; i++) begin
      if (x >= (WIDTH_W+1)'(i * US_PER_BIT)) begin
        q = CNT_W'(i);
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

@@ rtl/spfd_if.sv @@
// Valid/ready channel interfaces of the decoder: pulse pair input and
// channel result output. Depends on spfd_pkg.
`default_nettype none

interface spfd_in_if
  import spfd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] high_width;
  logic [WIDTH_W-1:0] low_width;

  modport source (output valid, high_width, low_width, input ready);
  modport sink   (input valid, high_width, low_width, output ready);
endinterface

interface spfd_out_if
  import spfd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CH_AW-1:0] channel_index;
  logic [VAL_W-1:0] channel_value;
  logic             failsafe;
  logic             frame_lost;
  logic [FRM_W-1:0] good_frame_count;
  logic             last_channel;

  modport source (output valid, channel_index, channel_value, failsafe, frame_lost,
                  good_frame_count, last_channel, input ready);
  modport sink   (input valid, channel_index, channel_value, failsafe, frame_lost,
                  good_frame_count, last_channel, output ready);
endinterface

`default_nettype wire

@@ rtl/sbus_pulse_frame_decoder_top.sv @@
// S.BUS pulse frame decoder: character memory with read-modify-write per pulse
// pair, frame check pass and channel emit. Depends on spfd_pkg and spfd_if.
// Pulse pair: accepted in IDLE, written back the next cycle; no new pair is taken until then.
// Frame end: check pass over all character slots (a failed check drops the frame), then
// 16 results, each read (EM_RD) and loaded (EM_LD); loading stalls on out_ch back-pressure.
// Synchronous reset clears control state, character valid bits and frame counter.
`default_nettype none

module sbus_pulse_frame_decoder_top
  import spfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  spfd_in_if.sink    in_ch,
  spfd_out_if.source out_ch
);

  state_t                state_r;
  logic [SLOT_AW-1:0]    slot_r;
  logic [OFS_W-1:0]      ofs_r;
  logic [FRAME_BYTES-1:0] valid_r;
  logic [FRM_W-1:0]      frames_r;

  logic [SLOT_AW-1:0]    wr_addr_r;
  logic [SLOT_BITS-1:0]  mask_r;
  logic                  brk_r;

  logic [SLOT_AW-1:0]    ck_r;
  logic                  err_r;
  logic                  fs_r;
  logic                  lost_r;
  logic [ACC_W-1:0]      acc_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CH_AW-1:0]      chw_r;
  logic [CH_AW-1:0]      ch_r;

  logic [SLOT_BITS-1:0]  char_mem [FRAME_BYTES];
  logic [SLOT_BITS-1:0]  rd_data_r;
  logic                  rd_vld_r;
  logic [CH_BITS-1:0]    ch_mem [NUM_CHANNELS];
  logic [CH_BITS-1:0]    ch_rd_r;

  logic                  out_valid_r;
  logic [CH_AW-1:0]      out_index_r;
  logic [VAL_W-1:0]      out_value_r;
  logic                  out_fs_r;
  logic                  out_lost_r;
  logic [FRM_W-1:0]      out_frames_r;
  logic                  out_last_r;

  // pulse pair decode
  logic [CNT_W-1:0]      hb;
  logic [CNT_W-1:0]      lbs;
  logic [CNT_W:0]        hb_ofs;
  logic                  item_bad;
  logic [OFS_W-1:0]      hi_end;
  logic [OFS_W-1:0]      room;
  logic [CNT_W-1:0]      nlow;
  logic [CNT_W-1:0]      rem;
  logic                  brk;
  logic [OFS_W-1:0]      new_ofs;
  logic [SLOT_BITS-1:0]  mask;

  // frame check
  logic [SLOT_BITS-1:0]  ck_word;
  logic [SLOT_BITS-1:0]  ck_v;
  logic [7:0]            ck_byte;
  logic [SLOT_AW-1:0]    ck_idx;
  logic                  ck_ok;
  logic                  ck_proc;
  logic                  ck_data;
  logic [ACC_W-1:0]      acc_sum;
  logic [CNT_W-1:0]      cnt_sum;
  logic                  ch_full;

  logic                  mem_re;
  logic [SLOT_AW-1:0]    mem_ra;
  logic                  out_load;
  logic [13:0]           scaled;
  logic [VAL_W-1:0]      ch_value;

  assign hb       = bit_count({1'b0, in_ch.high_width} + (WIDTH_W+1)'(1));
  assign lbs      = bit_count({1'b0, in_ch.low_width} + (WIDTH_W+1)'(1));
  assign hb_ofs   = {1'b0, hb} + (CNT_W+1)'(ofs_r);
  assign item_bad = (slot_r == SLOT_AW'(FRAME_BYTES)) || (hb == '0) || (lbs == '0)
                    || (hb_ofs > (CNT_W+1)'(MAX_HIGH_END));
  assign hi_end   = hb_ofs[OFS_W-1:0];
  assign room     = OFS_W'(SLOT_BITS) - hi_end;
  assign nlow     = (lbs < CNT_W'(room)) ? lbs : CNT_W'(room);
  assign rem      = lbs - nlow;
  assign brk      = rem > CNT_W'(SLOT_BITS);
  assign new_ofs  = hi_end + nlow[OFS_W-1:0];
  assign mask     = ((SLOT_BITS'(1) << hb[OFS_W-1:0]) - SLOT_BITS'(1)) << ofs_r;

  assign ck_word  = rd_vld_r ? rd_data_r : '0;
  assign ck_v     = ~ck_word;
  assign ck_byte  = ck_v[8:1];
  assign ck_idx   = ck_r - SLOT_AW'(1);
  assign ck_proc  = (state_r == ST_CHECK) && (ck_r != '0);
  assign ck_ok    = !ck_v[0] && ck_v[SLOT_BITS-1] && ck_v[SLOT_BITS-2] && !(^ck_v[9:1])
                    && ((ck_idx != '0) || (ck_byte == HEADER_BYTE));
  assign ck_data  = (ck_idx != '0) && (ck_idx < SLOT_AW'(FLAGS_SLOT));
  assign acc_sum  = acc_r | ({(ACC_W-8)'(0), ck_byte} << cnt_r);
  assign cnt_sum  = cnt_r + CNT_W'(8);
  assign ch_full  = cnt_sum >= CNT_W'(CH_BITS);

  assign mem_ra   = (state_r == ST_CHECK) ? ck_r : slot_r;
  assign mem_re   = ((state_r == ST_IDLE) || (state_r == ST_CHECK))
                    && (mem_ra < SLOT_AW'(FRAME_BYTES));

  assign out_load = (state_r == ST_EM_LD) && (!out_valid_r || out_ch.ready);
  assign scaled   = ({3'b0, ch_rd_r} << 2) + {3'b0, ch_rd_r} + 14'd4;
  assign ch_value = {1'b0, scaled[13:3]} + VAL_W'(CH_OFFSET);

  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.channel_index    = out_index_r;
  assign out_ch.channel_value    = out_value_r;
  assign out_ch.failsafe         = out_fs_r;
  assign out_ch.frame_lost       = out_lost_r;
  assign out_ch.good_frame_count = out_frames_r;
  assign out_ch.last_channel     = out_last_r;

  // character memory
  always_ff @(posedge clk) begin
    if (state_r == ST_WR) begin
      char_mem[wr_addr_r] <= (rd_vld_r ? rd_data_r : '0) | mask_r;
    end
    if (mem_re) begin
      rd_data_r <= char_mem[mem_ra];
      rd_vld_r  <= valid_r[mem_ra];
    end
  end

  // channel memory
  always_ff @(posedge clk) begin
    if (ck_proc && ck_data && ch_full) begin
      ch_mem[chw_r] <= acc_sum[CH_BITS-1:0];
    end
    if (state_r == ST_EM_RD) begin
      ch_rd_r <= ch_mem[ch_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r  <= ch_r;
      out_value_r  <= ch_value;
      out_fs_r     <= fs_r;
      out_lost_r   <= lost_r;
      out_frames_r <= frames_r;
      out_last_r   <= (ch_r == CH_AW'(NUM_CHANNELS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      ofs_r       <= '0;
      valid_r     <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
      ck_r        <= '0;
      err_r       <= 1'b0;
      fs_r        <= 1'b0;
      lost_r      <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      chw_r       <= '0;
      ch_r        <= '0;
      wr_addr_r   <= '0;
      mask_r      <= '0;
      brk_r       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (item_bad) begin
              valid_r <= '0;
              slot_r  <= '0;
              ofs_r   <= '0;
            end else begin
              wr_addr_r <= slot_r;
              mask_r    <= mask;
              brk_r     <= brk;
              if (new_ofs == OFS_W'(SLOT_BITS)) begin
                slot_r <= slot_r + SLOT_AW'(1);
                ofs_r  <= '0;
              end else begin
                ofs_r <= new_ofs;
              end
              state_r <= ST_WR;
            end
          end
        end

        ST_WR: begin
          if (brk_r && (slot_r != SLOT_AW'(FRAME_BYTES))) begin
            valid_r <= '0;
            slot_r  <= '0;
            ofs_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            valid_r[wr_addr_r] <= 1'b1;
            if (brk_r) begin
              state_r <= ST_CHECK;
              ck_r    <= '0;
              err_r   <= 1'b0;
              acc_r   <= '0;
              cnt_r   <= '0;
              chw_r   <= '0;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end

        ST_CHECK: begin
          ck_r <= ck_r + SLOT_AW'(1);
          if (ck_r != '0) begin
            err_r <= err_r | !ck_ok;
            if (ck_idx == SLOT_AW'(FLAGS_SLOT)) begin
              fs_r   <= ck_byte[3];
              lost_r <= ck_byte[3] | ck_byte[2];
            end
            if (ck_data) begin
              if (ch_full) begin
                acc_r <= acc_sum >> CH_BITS;
                cnt_r <= cnt_sum - CNT_W'(CH_BITS);
                chw_r <= chw_r + CH_AW'(1);
              end else begin
                acc_r <= acc_sum;
                cnt_r <= cnt_sum;
              end
            end
          end
          if (ck_r == SLOT_AW'(FRAME_BYTES)) begin
            if (err_r || !ck_ok) begin
              valid_r <= '0;
              slot_r  <= '0;
              ofs_r   <= '0;
              state_r <= ST_IDLE;
            end else begin
              if (!fs_r) begin
                frames_r <= frames_r + FRM_W'(1);
              end
              ch_r    <= '0;
              state_r <= ST_EM_RD;
            end
          end
        end

        ST_EM_RD: begin
          state_r <= ST_EM_LD;
        end

        ST_EM_LD: begin
          if (out_load) begin
            if (ch_r == CH_AW'(NUM_CHANNELS - 1)) begin
              valid_r <= '0;
              slot_r  <= '0;
              ofs_r   <= '0;
              state_r <= ST_IDLE;
            end else begin
              ch_r    <= ch_r + CH_AW'(1);
              state_r <= ST_EM_RD;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
